// ----- rtl/rdp_pkg.sv -----
// Shared types, constants and field positions for the register data-processing unit.
`default_nettype none
package rdp_pkg;

	localparam int XLen     = 64;
	localparam int WLen     = 32;
	localparam int NumRegs  = 31;
	localparam int IdxW     = 5;
	localparam int InDataW  = 104;
	localparam int OutDataW = 80;

	localparam logic [IdxW-1:0] ZeroReg   = 5'd31;
	localparam logic [3:0]      FlagsInit = 4'b0100;

	localparam logic OpExec = 1'b0;
	localparam logic OpLoad = 1'b1;

	localparam logic [1:0] ShLsl = 2'd0;
	localparam logic [1:0] ShLsr = 2'd1;
	localparam logic [1:0] ShAsr = 2'd2;
	localparam logic [1:0] ShRor = 2'd3;

	localparam logic [1:0] OpcAnd  = 2'd0;
	localparam logic [1:0] OpcOrr  = 2'd1;
	localparam logic [1:0] OpcEor  = 2'd2;
	localparam logic [1:0] OpcAnds = 2'd3;

	localparam int BitSf    = 31;
	localparam int BitMul   = 28;
	localparam int BitArith = 24;
	localparam int BitInv   = 21;
	localparam int BitMsub  = 15;

	typedef struct packed {
		logic [XLen-1:0] value;
		logic [3:0]      nzcv;
		logic            bad;
	} exec_res_t;

	function automatic logic [XLen-1:0] width_mask(input logic sf);
		width_mask = sf ? {XLen{1'b1}} : {{(XLen-WLen){1'b0}}, {WLen{1'b1}}};
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rdp_exec.sv -----
// Shifter, add/sub and logical unit with NZCV generation.
`default_nettype none
module rdp_exec (
	input  wire logic [31:0]                 instruction,
	input  wire logic [rdp_pkg::XLen-1:0]    rn,
	input  wire logic [rdp_pkg::XLen-1:0]    rm,
	input  wire logic [3:0]                  flags,
	output rdp_pkg::exec_res_t               res
);

	always_comb begin
		logic                       sf;
		logic [1:0]                 opc;
		logic [1:0]                 st;
		logic [5:0]                 amt;
		logic [rdp_pkg::XLen-1:0]   mask;
		logic [rdp_pkg::XLen-1:0]   x;
		logic [rdp_pkg::XLen-1:0]   xe;
		logic [rdp_pkg::XLen-1:0]   op2;
		logic [2*rdp_pkg::XLen-1:0] rot;
		logic [rdp_pkg::XLen-1:0]   b;
		logic [rdp_pkg::XLen:0]     sum;
		logic [rdp_pkg::XLen-1:0]   r;
		logic                       c;
		logic                       v;
		logic [rdp_pkg::XLen-1:0]   ovf;

		sf   = instruction[rdp_pkg::BitSf];
		opc  = instruction[30:29];
		st   = instruction[23:22];
		amt  = instruction[15:10];
		mask = rdp_pkg::width_mask(sf);
		x    = rm & mask;
		xe   = sf ? x : {{(rdp_pkg::XLen-rdp_pkg::WLen){x[rdp_pkg::WLen-1]}},
			x[rdp_pkg::WLen-1:0]};
		rot  = '0;

		unique case (st)
			rdp_pkg::ShLsl: op2 = (x << amt) & mask;
			rdp_pkg::ShLsr: op2 = x >> amt;
			rdp_pkg::ShAsr: op2 = 64'($signed(xe) >>> amt) & mask;
			rdp_pkg::ShRor: begin
				if (sf) begin
					rot = {x, x} >> amt;
					op2 = rot[rdp_pkg::XLen-1:0];
				end else begin
					rot = {64'd0, x[31:0], x[31:0]} >> amt[4:0];
					op2 = {32'd0, rot[31:0]};
				end
			end
			default: op2 = x;
		endcase

		res.bad   = 1'b0;
		res.nzcv  = flags;
		res.value = '0;
		b   = '0;
		sum = '0;
		r   = '0;
		c   = 1'b0;
		v   = 1'b0;
		ovf = '0;

		if (instruction[rdp_pkg::BitArith]) begin
			if (st == rdp_pkg::ShRor) begin
				res.bad = 1'b1;
			end else begin
				b   = opc[1] ? (~op2 & mask) : op2;
				sum = {1'b0, rn} + {1'b0, b} + {{rdp_pkg::XLen{1'b0}}, opc[1]};
				r   = sum[rdp_pkg::XLen-1:0] & mask;
				c   = sf ? sum[rdp_pkg::XLen] : sum[rdp_pkg::WLen];
				ovf = ~(rn ^ b) & (rn ^ r);
				v   = sf ? ovf[rdp_pkg::XLen-1] : ovf[rdp_pkg::WLen-1];
				res.value = r;
				if (opc[0])
					res.nzcv = {sf ? r[rdp_pkg::XLen-1] : r[rdp_pkg::WLen-1],
						r == '0, c, v};
			end
		end else begin
			if (instruction[rdp_pkg::BitInv])
				op2 = ~op2 & mask;
			case (opc)
				rdp_pkg::OpcAnd: res.value = rn & op2;
				rdp_pkg::OpcOrr: res.value = rn | op2;
				rdp_pkg::OpcEor: res.value = rn ^ op2;
				default: begin
					res.value = rn & op2;
					res.nzcv  = {sf ? res.value[rdp_pkg::XLen-1] : res.value[rdp_pkg::WLen-1],
						res.value == '0, 2'b00};
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/arm64_register_data_processing_unit.sv -----
// Top level: register file memories, operand forwarding, multiplier and output stage.
//
//  port group  dir  beat contents
//  s_axis      in   tdata: instruction, load_index, load_value; tuser: operation
//  m_axis      out  tdata: dest_index, dest_value, flags_nzcv; tuser: wrote, invalid
//
// Non-multiply beats: one per cycle unless the output stalls; each passes through the
// execute stage and output register. Multiply-add/sub steps through partial products,
// sum and accumulate in the execute stage; the input is held off meanwhile.
// Operands written by the previous beat are forwarded from the output register.
// Reset clears the register valid bits (registers read as zero) and sets Z.
// A stalled output holds the execute stage and then the input.
`default_nettype none
module arm64_register_data_processing_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] instruction, [36:32] load_index, [100:37] load_value
	input  wire logic [rdp_pkg::InDataW-1:0]   s_axis_tdata,
	// [0] operation
	input  wire logic                          s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [4:0] dest_index, [68:5] dest_value, [72:69] flags_nzcv
	output logic [rdp_pkg::OutDataW-1:0]       m_axis_tdata,
	// [0] wrote, [1] invalid
	output logic [1:0]                         m_axis_tuser
);

	logic [rdp_pkg::XLen-1:0] mem_a [0:rdp_pkg::NumRegs-1];
	logic [rdp_pkg::XLen-1:0] mem_b [0:rdp_pkg::NumRegs-1];
	logic [rdp_pkg::NumRegs-1:0] vld_q;
	logic [3:0] flags_q;

	logic acc;
	logic [rdp_pkg::IdxW-1:0] rn_a, rm_a, ra_a;

	logic                      s1_valid;
	logic                      op_s1;
	logic [31:0]               ins_s1;
	logic [rdp_pkg::IdxW-1:0]  lidx_s1;
	logic [rdp_pkg::XLen-1:0]  lval_s1;
	logic [rdp_pkg::XLen-1:0]  rn_rd_s1, rm_rd_s1, ra_rd_s1;
	logic                      rn_live_s1, rm_live_s1, ra_live_s1;

	logic [1:0]               mul_cnt_q;
	logic [63:0]              pp_ll_q;
	logic [31:0]              pp_hl_q, pp_lh_q;
	logic [rdp_pkg::XLen-1:0] ra_q;
	logic [rdp_pkg::XLen-1:0] prod_q;

	logic                      s2_valid;
	logic [rdp_pkg::IdxW-1:0]  idx_s2;
	logic [rdp_pkg::XLen-1:0]  val_s2;
	logic                      wrote_s2;
	logic                      bad_s2;
	logic [3:0]                flags_s2;
	logic                      wr_last_q;

	logic [rdp_pkg::XLen-1:0] mask_s1;
	logic [rdp_pkg::XLen-1:0] rn_op, rm_op, ra_op;
	logic                     is_mul;
	logic                     s1_done;
	logic                     s1_adv;
	rdp_pkg::exec_res_t       ex;

	logic [rdp_pkg::IdxW-1:0] res_idx;
	logic [rdp_pkg::XLen-1:0] res_val;
	logic [3:0]               res_flags;
	logic                     res_bad;
	logic                     res_wrote;
	logic [rdp_pkg::XLen-1:0] mul_val;

	function automatic logic [rdp_pkg::XLen-1:0] pick(
		input logic [rdp_pkg::IdxW-1:0] a,
		input logic [rdp_pkg::XLen-1:0] rd,
		input logic                     live,
		input logic                     fwd,
		input logic [rdp_pkg::IdxW-1:0] fidx,
		input logic [rdp_pkg::XLen-1:0] fval
	);
		if (a == rdp_pkg::ZeroReg)
			pick = '0;
		else if (fwd && fidx == a)
			pick = fval;
		else
			pick = live ? rd : '0;
	endfunction

	assign rn_a = s_axis_tdata[9:5];
	assign rm_a = s_axis_tdata[20:16];
	assign ra_a = s_axis_tdata[14:10];
	assign acc  = s_axis_tvalid && s_axis_tready;

	assign is_mul  = (op_s1 == rdp_pkg::OpExec) && ins_s1[rdp_pkg::BitMul];
	assign s1_done = !is_mul || mul_cnt_q == 2'd2;
	assign s1_adv  = s1_valid && s1_done && (!s2_valid || m_axis_tready);
	assign s_axis_tready = !s1_valid || s1_adv;

	assign mask_s1 = rdp_pkg::width_mask(ins_s1[rdp_pkg::BitSf]);
	assign rn_op = pick(ins_s1[9:5], rn_rd_s1, rn_live_s1, wr_last_q, idx_s2, val_s2)
		& mask_s1;
	assign rm_op = pick(ins_s1[20:16], rm_rd_s1, rm_live_s1, wr_last_q, idx_s2, val_s2)
		& mask_s1;
	assign ra_op = pick(ins_s1[14:10], ra_rd_s1, ra_live_s1, wr_last_q, idx_s2, val_s2)
		& mask_s1;

	rdp_exec u_exec (
		.instruction (ins_s1),
		.rn          (rn_op),
		.rm          (rm_op),
		.flags       (flags_q),
		.res         (ex)
	);

	assign mul_val = (ins_s1[rdp_pkg::BitMsub] ? ra_q - prod_q : ra_q + prod_q) & mask_s1;

	always_comb begin
		res_bad   = 1'b0;
		res_flags = flags_q;
		if (op_s1 == rdp_pkg::OpLoad) begin
			res_idx = lidx_s1;
			res_val = lval_s1;
		end else if (is_mul) begin
			res_idx = ins_s1[4:0];
			res_val = mul_val;
		end else begin
			res_idx   = ins_s1[4:0];
			res_val   = ex.value;
			res_flags = ex.nzcv;
			res_bad   = ex.bad;
		end
		if (res_bad) begin
			res_idx = '0;
			res_val = '0;
		end
		res_wrote = !res_bad && res_idx != rdp_pkg::ZeroReg;
	end

	// register file copies: a serves Rn/Rm, b serves Ra
	always_ff @(posedge clk) begin
		if (s1_adv && res_wrote) begin
			mem_a[res_idx] <= res_val;
			mem_b[res_idx] <= res_val;
		end
		if (acc) begin
			rn_rd_s1 <= mem_a[rn_a];
			rm_rd_s1 <= mem_a[rm_a];
			ra_rd_s1 <= mem_b[ra_a];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1      <= s_axis_tuser;
			ins_s1     <= s_axis_tdata[31:0];
			lidx_s1    <= s_axis_tdata[36:32];
			lval_s1    <= s_axis_tdata[100:37];
			rn_live_s1 <= (rn_a == rdp_pkg::ZeroReg) ? 1'b0 : vld_q[rn_a];
			rm_live_s1 <= (rm_a == rdp_pkg::ZeroReg) ? 1'b0 : vld_q[rm_a];
			ra_live_s1 <= (ra_a == rdp_pkg::ZeroReg) ? 1'b0 : vld_q[ra_a];
		end
		if (s1_valid && is_mul && mul_cnt_q == 2'd0) begin
			pp_ll_q <= {32'd0, rn_op[31:0]} * {32'd0, rm_op[31:0]};
			pp_hl_q <= rn_op[63:32] * rm_op[31:0];
			pp_lh_q <= rn_op[31:0] * rm_op[63:32];
			ra_q    <= ra_op;
		end
		if (s1_valid && is_mul && mul_cnt_q == 2'd1)
			prod_q <= pp_ll_q + {pp_hl_q + pp_lh_q, 32'd0};
		if (s1_adv) begin
			idx_s2   <= res_idx;
			val_s2   <= res_val;
			wrote_s2 <= res_wrote;
			bad_s2   <= res_bad;
			flags_s2 <= res_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid  <= 1'b0;
			s2_valid  <= 1'b0;
			mul_cnt_q <= '0;
			vld_q     <= '0;
			flags_q   <= rdp_pkg::FlagsInit;
			wr_last_q <= 1'b0;
		end else begin
			if (acc)
				s1_valid <= 1'b1;
			else if (s1_adv)
				s1_valid <= 1'b0;
			if (s1_adv)
				s2_valid <= 1'b1;
			else if (m_axis_tready)
				s2_valid <= 1'b0;
			if (s1_adv)
				mul_cnt_q <= '0;
			else if (s1_valid && is_mul && mul_cnt_q != 2'd2)
				mul_cnt_q <= mul_cnt_q + 2'd1;
			if (s1_adv) begin
				flags_q   <= res_flags;
				wr_last_q <= res_wrote;
				if (res_wrote)
					vld_q[res_idx] <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = s2_valid;
	assign m_axis_tdata  = {7'd0, flags_s2, val_s2, idx_s2};
	assign m_axis_tuser  = {bad_s2, wrote_s2};

	a_mul_len: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && is_mul |-> mul_cnt_q == 2'd2)
		else $error("multiply left execute early");
	a_cnt_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_cnt_q != 2'd0 |-> s1_valid && is_mul)
		else $error("multiply count without multiply");
	a_no_zero_wr: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && res_wrote |-> res_idx != rdp_pkg::ZeroReg)
		else $error("write to zero register");
	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> m_axis_tvalid)
		else $error("result lost");
	a_bad_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && m_axis_tdata[68:0] == '0)
		else $error("invalid beat carries a write");

endmodule
`default_nettype wire
